[hdl/edpid_pkg.sv]
// ----------------------------------------------------------------------------
// edpid_pkg: shared types and microcode for the echo distance PID block
// Holds the control word layout, the program ROM and the fixed constants.
// ----------------------------------------------------------------------------
package edpid_pkg;

  localparam int unsigned STEP_W   = 3;
  localparam int unsigned ACC_W    = 50;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned TICKS_W  = 16;
  localparam int unsigned DIST_W   = 13;
  localparam int unsigned ERR_W    = 16;
  localparam int unsigned DIFF_W   = 17;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned LIMIT_W  = 15;
  localparam int unsigned DRIVE_W  = 16;
  localparam int unsigned Q_SHIFT  = 12;

  // floor(t * 1.73) == (t * 907019) >> 19 for every t below the timeout.
  localparam logic [19:0] DIST_MULT  = 20'd907019;
  localparam int unsigned DIST_SHIFT = 19;
  localparam logic [TICKS_W-1:0] TIMEOUT_TICKS = 16'd3800;

  // Configuration register indexes.
  localparam logic [2:0] REG_TARGET = 3'd0;
  localparam logic [2:0] REG_GAIN_P = 3'd1;
  localparam logic [2:0] REG_GAIN_I = 3'd2;
  localparam logic [2:0] REG_GAIN_D = 3'd3;
  localparam logic [2:0] REG_LIMIT  = 3'd4;

  typedef enum logic [1:0] {
    MUL_DIST,
    MUL_P,
    MUL_I,
    MUL_D
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_NO_INPUT,
    COND_OUT_FULL
  } cond_t;

  typedef struct packed {
    mul_sel_t          mul_sel;
    acc_op_t           acc_op;
    logic              take_in;
    logic              upd_err;
    logic              finish;
    logic              done;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // Program: wait and multiply ticks, form error terms, three gain products
  // accumulated one behind the multiplier, then round, clamp and emit.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{mul_sel: MUL_DIST, acc_op: ACC_HOLD, take_in: 1'b0, upd_err: 1'b0,
          finish: 1'b0, done: 1'b0, cond: COND_NEVER, target: '0};
    case (step)
      3'd0: begin
        w.take_in = 1'b1;
        w.cond    = COND_NO_INPUT;
        w.target  = 3'd0;
      end
      3'd1: begin
        w.upd_err = 1'b1;
      end
      3'd2: begin
        w.mul_sel = MUL_P;
      end
      3'd3: begin
        w.mul_sel = MUL_I;
        w.acc_op  = ACC_LOAD;
      end
      3'd4: begin
        w.mul_sel = MUL_D;
        w.acc_op  = ACC_ADD;
      end
      3'd5: begin
        w.acc_op  = ACC_ADD;
      end
      3'd6: begin
        w.finish  = 1'b1;
        w.done    = 1'b1;
        w.cond    = COND_OUT_FULL;
        w.target  = 3'd6;
      end
      default: begin
        w.done    = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

[hdl/echo_distance_pid.sv]
// ----------------------------------------------------------------------------
// echo_distance_pid: sonar echo width to distance, PID with clamped output
// Each request runs the microcode from the wait step through the error,
// product, accumulate and finish steps (finish stalls while the output is
// full) before the next is taken; one 17x33 multiplier serves all products.
// A finished result waits in the output register while the next request runs.
// Reset (rst, synchronous) restores register defaults and clears the PID state.
// ----------------------------------------------------------------------------
module echo_distance_pid (
  input  logic        clk,
  input  logic        rst,
  // Input stream. s_tdata: [15:0] echo_ticks.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,
  // Output stream. m_tdata: [15:0] drive, [16] motor_update,
  // [29:17] range_mm, [30] timed_out, [31] zero.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers.
  logic [edpid_pkg::DIST_W-1:0]  target_mm;
  logic [edpid_pkg::GAIN_W-1:0]  gain_p;
  logic [edpid_pkg::GAIN_W-1:0]  gain_i;
  logic [edpid_pkg::GAIN_W-1:0]  gain_d;
  logic [edpid_pkg::LIMIT_W-1:0] drive_limit;

  // Sequencer.
  logic [edpid_pkg::STEP_W-1:0] step;
  logic [edpid_pkg::STEP_W-1:0] step_next;
  edpid_pkg::ucode_t            uc;
  logic                         cond_true;

  // Datapath registers.
  logic                                timed_out;
  logic [edpid_pkg::DIST_W-1:0]        distance;
  logic signed [edpid_pkg::ERR_W-1:0]  err;
  logic signed [edpid_pkg::ERR_W-1:0]  last_error;
  logic signed [edpid_pkg::DIFF_W-1:0] diff;
  logic signed [edpid_pkg::SUM_W-1:0]  error_sum;
  logic signed [edpid_pkg::ACC_W-1:0]  prod;
  logic signed [edpid_pkg::ACC_W-1:0]  acc;

  // Output register.
  logic                                 out_valid;
  logic signed [edpid_pkg::DRIVE_W-1:0] out_drive;
  logic                                 out_update;
  logic [edpid_pkg::DIST_W-1:0]         out_dist;
  logic                                 out_tmo;

  // Combinational datapath.
  logic signed [16:0]                  mul_a;
  logic signed [32:0]                  mul_b;
  logic [edpid_pkg::DIST_W-1:0]        dist_next;
  logic signed [edpid_pkg::ERR_W-1:0]  err_next;
  logic signed [edpid_pkg::SUM_W:0]    sum_wide;
  logic signed [edpid_pkg::SUM_W-1:0]  sum_next;
  logic signed [edpid_pkg::DIFF_W-1:0] diff_next;
  logic signed [edpid_pkg::ACC_W-1:0]  acc_round;
  logic signed [edpid_pkg::ACC_W-edpid_pkg::Q_SHIFT-1:0] quot;
  logic signed [edpid_pkg::ACC_W-edpid_pkg::Q_SHIFT-1:0] lim_pos;
  logic signed [edpid_pkg::ACC_W-edpid_pkg::Q_SHIFT-1:0] lim_neg;
  logic signed [edpid_pkg::DRIVE_W-1:0] drive_next;
  logic                                 update_next;
  logic                                 out_full;
  logic                                 in_req;

  assign uc        = edpid_pkg::ucode_rom(step);
  assign out_full  = out_valid && !m_tready;
  assign s_tready  = uc.take_in;
  assign in_req    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Jump when the step's condition holds; otherwise fall through, and the
  // last step of the program wraps back to the wait step.
  always_comb begin
    case (uc.cond)
      edpid_pkg::COND_NO_INPUT: cond_true = !s_tvalid;
      edpid_pkg::COND_OUT_FULL: cond_true = out_full;
      default:                  cond_true = 1'b0;
    endcase
    if (cond_true) begin
      step_next = uc.target;
    end else if (uc.done) begin
      step_next = '0;
    end else begin
      step_next = step + 1'b1;
    end
  end

  // Operand selection for the shared multiplier. Gains and ticks are unsigned
  // and enter with a zero sign bit.
  always_comb begin
    case (uc.mul_sel)
      edpid_pkg::MUL_P: begin
        mul_a = $signed({1'b0, gain_p});
        mul_b = 33'(err);
      end
      edpid_pkg::MUL_I: begin
        mul_a = $signed({1'b0, gain_i});
        mul_b = 33'(error_sum);
      end
      edpid_pkg::MUL_D: begin
        mul_a = $signed({1'b0, gain_d});
        mul_b = 33'(diff);
      end
      default: begin
        mul_a = $signed({1'b0, s_tdata});
        mul_b = $signed({13'd0, edpid_pkg::DIST_MULT});
      end
    endcase
  end

  // Error terms, formed from the distance product.
  always_comb begin
    dist_next = timed_out ? '0
              : prod[edpid_pkg::DIST_SHIFT +: edpid_pkg::DIST_W];
    err_next  = $signed({3'b000, dist_next}) - $signed({3'b000, target_mm});
    sum_wide  = 33'(error_sum) + 33'(err_next);
    // Saturate when the two top bits disagree.
    if (sum_wide[32] != sum_wide[31]) begin
      sum_next = sum_wide[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      sum_next = sum_wide[31:0];
    end
    diff_next = 17'(err_next) - 17'(last_error);
  end

  // Divide by 4096 truncating toward zero, then clamp to the limit.
  always_comb begin
    acc_round = acc[edpid_pkg::ACC_W-1] ? acc + 50'sd4095 : acc;
    quot      = acc_round[edpid_pkg::ACC_W-1:edpid_pkg::Q_SHIFT];
    lim_pos   = $signed({23'd0, drive_limit});
    lim_neg   = -lim_pos;
    if (quot > lim_pos) begin
      drive_next = lim_pos[edpid_pkg::DRIVE_W-1:0];
    end else if (quot < lim_neg) begin
      drive_next = lim_neg[edpid_pkg::DRIVE_W-1:0];
    end else begin
      drive_next = quot[edpid_pkg::DRIVE_W-1:0];
    end
    // The motor flag follows the sign of the full sum, except that a zero
    // limit always gives a drive of zero, which counts as not negative.
    update_next = !(acc[edpid_pkg::ACC_W-1] && (drive_limit != '0));
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      step        <= '0;
      out_valid   <= 1'b0;
      error_sum   <= '0;
      last_error  <= '0;
      target_mm   <= 13'd200;
      gain_p      <= 16'd4096;
      gain_i      <= 16'd205;
      gain_d      <= 16'd1229;
      drive_limit <= 15'd1000;
    end else begin
      step <= step_next;
      if (cfg_valid) begin
        case (cfg_index)
          edpid_pkg::REG_TARGET: target_mm   <= cfg_data[edpid_pkg::DIST_W-1:0];
          edpid_pkg::REG_GAIN_P: gain_p      <= cfg_data;
          edpid_pkg::REG_GAIN_I: gain_i      <= cfg_data;
          edpid_pkg::REG_GAIN_D: gain_d      <= cfg_data;
          edpid_pkg::REG_LIMIT:  drive_limit <= cfg_data[edpid_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (uc.upd_err) begin
        error_sum  <= sum_next;
        last_error <= err_next;
      end
      if (uc.finish && !out_full) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (in_req) begin
      timed_out <= (s_tdata >= edpid_pkg::TIMEOUT_TICKS);
    end
    if (uc.upd_err) begin
      distance <= dist_next;
      err      <= err_next;
      diff     <= diff_next;
    end
    case (uc.acc_op)
      edpid_pkg::ACC_LOAD: acc <= prod;
      edpid_pkg::ACC_ADD:  acc <= acc + prod;
      default: ;
    endcase
    if (uc.finish && !out_full) begin
      out_drive  <= drive_next;
      out_update <= update_next;
      out_dist   <= distance;
      out_tmo    <= timed_out;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_tmo, out_dist, out_update, out_drive};

endmodule
